// ===== rtl/core/nrss_pkg.sv =====
// Package of the nearest request seek scheduler: payload word types,
// command and status structs between controller and datapath, and constants.
// No dependencies.
package nrss_pkg;

   localparam int POS_W  = 10;
   localparam int CNT_W  = 16;
   localparam int SUM_W  = 32;
   // Seek distance counter; wide enough for head plus one step past the end.
   localparam int DIST_W = 12;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_SERVE = 1'b1;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] moved;
      logic [POS_W-1:0] head_now;
      logic [SUM_W-1:0] total_moved;
   } rsp_type;

   typedef struct packed {
      logic take_item;
      logic scan;
      logic scan_start;
      logic scan_step;
      logic add_write;
      logic commit;
      logic give_none;
      logic clear_write;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic scan_end;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/nrss_ctrl.sv =====
// Controller of the nearest request seek scheduler: sequences the clearing
// pass, add and serve items and the result hand-off. Uses nrss_pkg.
module nrss_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_kind,
   output logic             req_ready,
   input  nrss_pkg::sts_type sts,
   output nrss_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == ST_IDLE);

   // Command decode from the current state and status.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         ST_IDLE: begin
            cmd.take_item  = req_valid;
            cmd.scan_start = req_valid && (req_kind == nrss_pkg::KIND_SERVE);
         end
         ST_ADD_READ: begin
            cmd.scan = 1'b0;
         end
         ST_ADD_WRITE: begin
            cmd.add_write = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               cmd.commit = 1'b1;
            end else if (sts.scan_end) begin
               cmd.give_none = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_RESULT: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (sts.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_kind == nrss_pkg::KIND_SERVE) ? ST_SCAN : ST_ADD_READ;
               end
            end
            ST_ADD_READ: begin
               state_ff <= ST_ADD_WRITE;
            end
            ST_ADD_WRITE: begin
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               if (sts.hit || sts.scan_end) state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (sts.out_free) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/nrss_datapath.sv =====
// Datapath of the nearest request seek scheduler: count memory, head and
// direction, distance sum, outward seek counter and output register. Uses nrss_pkg.
module nrss_datapath #(
   parameter int POSITIONS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  nrss_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic [nrss_pkg::POS_W-1:0] csr_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output nrss_pkg::rsp_type rsp_data,
   input  nrss_pkg::cmd_type cmd,
   output nrss_pkg::sts_type sts
);

   localparam int AW   = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int LAST = POSITIONS - 1;
   localparam int DW   = nrss_pkg::DIST_W;
   localparam int PW   = nrss_pkg::POS_W;
   localparam int CW   = nrss_pkg::CNT_W;
   localparam int SW   = nrss_pkg::SUM_W;

   logic [CW-1:0] count_mem [POSITIONS];

   logic [PW-1:0]     track_end_ff;
   logic [PW-1:0]     head_ff;
   logic              right_ff;
   logic [SW-1:0]     sum_ff;
   nrss_pkg::req_type item_ff;
   logic [DW-1:0]     dist_ff;
   logic [DW-1:0]     chk_dist_ff;
   logic              chk_valid_ff;
   logic              chk_left_ff;
   logic              chk_right_ff;
   logic              chk_end_ff;
   logic [AW-1:0]     clear_addr_ff;
   logic [CW-1:0]     rd_a_ff;
   logic [CW-1:0]     rd_b_ff;
   nrss_pkg::rsp_type res_ff;
   nrss_pkg::rsp_type out_ff;
   logic              out_valid_ff;

   logic [PW-1:0]     lim;
   logic [DW-1:0]     head_ext;
   logic [DW-1:0]     lim_ext;
   logic [DW-1:0]     left_val;
   logic [DW-1:0]     right_val;
   logic              left_ok;
   logic              right_ok;
   logic              seek_end;
   logic              hit_l;
   logic              hit_r;
   logic              go_right;
   logic [DW-1:0]     target;
   logic [CW-1:0]     served_cnt;
   logic [SW:0]       sum_ext;
   logic [SW-1:0]     sum_in;
   logic              add_ok;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CW-1:0]     mem_wd;
   logic [AW-1:0]     mem_ra;
   logic [AW-1:0]     mem_rb;

   // Highest searchable position: the register, capped by the store depth.
   always_comb begin
      if (17'(track_end_ff) > 17'(LAST)) begin
         lim = PW'(LAST);
      end else begin
         lim = track_end_ff;
      end
   end

   // Candidate positions at the current seek distance on either side.
   always_comb begin
      head_ext  = DW'(head_ff);
      lim_ext   = DW'(lim);
      left_val  = head_ext - dist_ff;
      right_val = head_ext + dist_ff;
      left_ok   = (dist_ff <= head_ext) && (left_val <= lim_ext);
      right_ok  = (right_val <= lim_ext);
      seek_end  = (dist_ff > head_ext) && !right_ok;
   end

   // Hit decision on the counts read for the previous distance.
   always_comb begin
      hit_l = chk_left_ff && (rd_a_ff != '0);
      hit_r = chk_right_ff && (rd_b_ff != '0);
      if ((chk_dist_ff == '0) || (hit_l && hit_r)) begin
         go_right = right_ff;
      end else begin
         go_right = hit_r;
      end
      target     = go_right ? (head_ext + chk_dist_ff) : (head_ext - chk_dist_ff);
      served_cnt = go_right ? rd_b_ff : rd_a_ff;
      sum_ext    = (SW+1)'(sum_ff) + (SW+1)'(chk_dist_ff);
      sum_in     = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
      add_ok     = (item_ff.position <= lim) && (rd_a_ff != nrss_pkg::COUNT_MAX);
   end

   assign sts.hit        = chk_valid_ff && (hit_l || hit_r);
   assign sts.scan_end   = chk_valid_ff && chk_end_ff;
   assign sts.clear_last = (clear_addr_ff == AW'(LAST));
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   // Memory port selection.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = AW'(item_ff.position);
      mem_wd = rd_a_ff + 1'b1;
      if (cmd.clear_write) begin
         mem_we = 1'b1;
         mem_wa = clear_addr_ff;
         mem_wd = '0;
      end else if (cmd.commit) begin
         mem_we = 1'b1;
         mem_wa = AW'(target);
         mem_wd = served_cnt - 1'b1;
      end else if (cmd.add_write) begin
         mem_we = add_ok;
      end
      mem_ra = cmd.scan ? AW'(left_val) : AW'(item_ff.position);
      mem_rb = AW'(right_val);
   end

   // Count memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) count_mem[mem_wa] <= mem_wd;
      rd_a_ff <= count_mem[mem_ra];
      rd_b_ff <= count_mem[mem_rb];
   end

   // Item capture and result word.
   always_ff @(posedge clock) begin
      if (cmd.take_item) item_ff <= req_data;
      if (cmd.commit) begin
         res_ff.found       <= 1'b1;
         res_ff.moved       <= PW'(chk_dist_ff);
         res_ff.head_now    <= PW'(target);
         res_ff.total_moved <= sum_in;
      end else if (cmd.give_none) begin
         res_ff.found       <= 1'b0;
         res_ff.moved       <= '0;
         res_ff.head_now    <= head_ff;
         res_ff.total_moved <= sum_ff;
      end
      if (cmd.load_out) out_ff <= res_ff;
   end

   // Scheduler state, seek counter and output handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_end_ff  <= PW'(1023);
         head_ff       <= '0;
         right_ff      <= 1'b1;
         sum_ff        <= '0;
         dist_ff       <= '0;
         chk_dist_ff   <= '0;
         chk_valid_ff  <= 1'b0;
         chk_left_ff   <= 1'b0;
         chk_right_ff  <= 1'b0;
         chk_end_ff    <= 1'b0;
         clear_addr_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) track_end_ff <= csr_data;
         if (cmd.clear_write) clear_addr_ff <= clear_addr_ff + 1'b1;
         if (cmd.scan_start) begin
            dist_ff      <= '0;
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            dist_ff      <= dist_ff + 1'b1;
            chk_dist_ff  <= dist_ff;
            chk_left_ff  <= left_ok;
            chk_right_ff <= right_ok;
            chk_end_ff   <= seek_end;
            chk_valid_ff <= 1'b1;
         end
         if (cmd.commit) begin
            head_ff <= PW'(target);
            if (chk_dist_ff != '0) right_ff <= go_right;
            sum_ff  <= sum_in;
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/nearest_request_seek_scheduler.sv =====
// Nearest request seek scheduler: an add word reads and then writes its count after
// acceptance. A serve word seeks out to d, d being the distance to the nearest pending
// request, or max(head, end - head) + 1 when none is pending in the range, as the
// seek steps one distance a cycle on both sides through two read ports of the store.
// After reset a clearing pass writes every count entry with req_ready low;
// configuration writes are taken at any time.
module nearest_request_seek_scheduler #(
   parameter int POSITIONS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nrss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nrss_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [nrss_pkg::POS_W-1:0] csr_data
);

   nrss_pkg::cmd_type cmd;
   nrss_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // Sequencer.
   nrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, head state and result register.
   nrss_datapath #(
      .POSITIONS (POSITIONS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the nearest request seek scheduler.
// Holds a scoreboard class that predicts every serve result, and tasks that drive
// the request and register channels, and a response process. Depends on nrss_pkg and the RTL top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int TRACK_POSITIONS = 1024;
   localparam int TRACK_TOP       = TRACK_POSITIONS - 1;
   // Cycles an add word may still be in flight once the last result is home.
   localparam int ADD_SETTLE      = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AFTER      = 40;
   localparam int IDLE_PERCENT    = 6;
   localparam int WATCHDOG_LIMIT  = 10000;

   // Predicts the result of every serve word and checks the block against it.
   class seek_scoreboard;
      bit [nrss_pkg::CNT_W-1:0] pending [TRACK_POSITIONS];
      bit [nrss_pkg::POS_W-1:0] head_pos;
      bit                       heading_right = 1'b1;
      bit [nrss_pkg::SUM_W-1:0] distance_sum;
      bit [nrss_pkg::POS_W-1:0] track_end = nrss_pkg::POS_W'(TRACK_TOP);
      nrss_pkg::rsp_type        awaited [$];
      int                       errors;

      function void set_track_end(logic [nrss_pkg::POS_W-1:0] value);
         track_end = value;
      endfunction

      function int depth();
         return awaited.size();
      endfunction

      // Applies one accepted request word to the predicted state.
      function void note_request(nrss_pkg::req_type w);
         int                       lim;
         int                       best;
         int                       gap;
         int                       head;
         bit                       any;
         bit                       left_ok;
         bit                       right_ok;
         bit                       go_right;
         bit [nrss_pkg::SUM_W-1:0] step;
         nrss_pkg::rsp_type        r;
         lim = (track_end > TRACK_TOP) ? TRACK_TOP : int'(track_end);
         if (w.kind == nrss_pkg::KIND_ADD) begin
            if (w.position <= lim && pending[w.position] != nrss_pkg::COUNT_MAX) begin
               pending[w.position]++;
            end
            return;
         end
         head = head_pos;
         best = 0;
         any  = 1'b0;
         // Nearest pending position within the searchable range.
         for (int p = 0; p <= lim; p++) begin
            if (pending[p] != 0) begin
               gap = (p > head) ? p - head : head - p;
               if (!any || gap < best) begin
                  best = gap;
               end
               any = 1'b1;
            end
         end
         if (!any) begin
            r.found       = 1'b0;
            r.moved       = '0;
            r.head_now    = head_pos;
            r.total_moved = distance_sum;
            awaited.push_back(r);
            return;
         end
         left_ok  = head >= best && head - best <= lim && pending[head - best] != 0;
         right_ok = head + best <= lim && pending[head + best] != 0;
         // A tie or a zero move keeps the direction; otherwise the move sets it.
         if (best == 0 || (left_ok && right_ok)) begin
            go_right = heading_right;
         end else begin
            go_right = right_ok;
         end
         if (best != 0) begin
            heading_right = go_right;
         end
         head     = go_right ? head + best : head - best;
         head_pos = nrss_pkg::POS_W'(head);
         if (head < TRACK_POSITIONS && pending[head] != 0) begin
            pending[head]--;
         end
         step = nrss_pkg::SUM_W'(best);
         if (distance_sum > {nrss_pkg::SUM_W{1'b1}} - step) begin
            distance_sum = {nrss_pkg::SUM_W{1'b1}};
         end else begin
            distance_sum = distance_sum + step;
         end
         r.found       = 1'b1;
         r.moved       = nrss_pkg::POS_W'(best);
         r.head_now    = head_pos;
         r.total_moved = distance_sum;
         awaited.push_back(r);
      endfunction

      // Compares one accepted result word with the oldest prediction.
      function void check_response(nrss_pkg::rsp_type got);
         nrss_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            $error("result word with no prediction waiting: %p", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
         end
         if (got.moved !== want.moved) begin
            $error("moved: expected %0d, actual %0d", want.moved, got.moved);
            errors++;
         end
         if (got.head_now !== want.head_now) begin
            $error("head_now: expected %0d, actual %0d", want.head_now, got.head_now);
            errors++;
         end
         if (got.total_moved !== want.total_moved) begin
            $error("total_moved: expected %0d, actual %0d", want.total_moved,
                   got.total_moved);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   nrss_pkg::req_type        req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   nrss_pkg::rsp_type        rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [nrss_pkg::POS_W-1:0] csr_data;

   seek_scoreboard    sb = new;
   int                sender_idle = IDLE_PERCENT;
   int                quiet_cycles = 0;

   nearest_request_seek_scheduler #(
      .POSITIONS(TRACK_POSITIONS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   function automatic nrss_pkg::req_type make_word(logic kind,
                                                   logic [nrss_pkg::POS_W-1:0] pos);
      nrss_pkg::req_type w;
      w.kind     = kind;
      w.position = pos;
      return w;
   endfunction

   // Offers one request word, with an occasional idle cycle first.
   task automatic send_word(input nrss_pkg::req_type w);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
   endtask

   // Waits for the block to go quiet, then writes the end of the track.
   task automatic change_track_end(input logic [nrss_pkg::POS_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.depth() != 0) @(posedge clock);
      repeat (ADD_SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_track_end(value);
   endtask

   // Random mix of adds and serves, mostly inside the searchable range.
   task automatic send_random_words(input int count);
      int                         lim;
      logic [nrss_pkg::POS_W-1:0] pos;
      logic                       kind;
      lim = int'(sb.track_end);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            pos = nrss_pkg::POS_W'($urandom_range(0, lim));
         end else begin
            pos = nrss_pkg::POS_W'($urandom_range(0, TRACK_TOP));
         end
         kind = ($urandom_range(0, 99) < 55) ? nrss_pkg::KIND_ADD : nrss_pkg::KIND_SERVE;
         send_word(make_word(kind, pos));
      end
   endtask

   // Response side: random stalls, one long hold-off and a stretch without stalls.
   initial begin : response_side
      int results_seen;
      int hold_left;
      bit held;
      results_seen = 0;
      hold_left    = 0;
      held         = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
            results_seen++;
         end
         if (!held && results_seen >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (results_seen >= 120 && results_seen < 200) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Ends the run when nothing has been accepted on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence: reset, directed words, then random phases at several track ends.
   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      change_track_end(nrss_pkg::POS_W'(TRACK_TOP));
      // Empty store, a zero move at the head, a one-sided move to the far end.
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_ADD, '0));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(TRACK_TOP)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_SERVE, nrss_pkg::POS_W'(TRACK_TOP)));
      // Move left, then a tie while heading left.
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(500)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(400)));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(600)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      // Turn right, then a tie while heading right.
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(800)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(500)));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(700)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      // A request at the head keeps the direction; then drain to empty.
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(700)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_SERVE, nrss_pkg::POS_W'(TRACK_TOP)));
      send_random_words(160);

      // Shortest track: only position 0 is searched; counts beyond it stay.
      change_track_end('0);
      send_word(make_word(nrss_pkg::KIND_ADD, '0));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(1)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_random_words(60);

      change_track_end(nrss_pkg::POS_W'(1));
      send_random_words(60);

      // Adds past the end are dropped; this phase runs without sender idling.
      change_track_end(nrss_pkg::POS_W'(63));
      sender_idle = 0;
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(100)));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(64)));
      send_word(make_word(nrss_pkg::KIND_ADD, nrss_pkg::POS_W'(63)));
      send_word(make_word(nrss_pkg::KIND_SERVE, '0));
      send_random_words(100);
      sender_idle = IDLE_PERCENT;

      change_track_end(nrss_pkg::POS_W'($urandom_range(2, TRACK_TOP - 1)));
      send_random_words(90);

      change_track_end(nrss_pkg::POS_W'(TRACK_TOP));
      send_random_words(80);

      // Let every prediction come home, then allow trailing adds to settle.
      req_valid <= 1'b0;
      while (sb.depth() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.depth() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/nrss_pkg.sv
rtl/core/nrss_ctrl.sv
rtl/core/nrss_datapath.sv
rtl/core/nearest_request_seek_scheduler.sv
verif/tb_top.sv
